### rtl/gifl_pkg.sv
// Shared constants, codes and types of the growable index free list.
`default_nettype none
package gifl_pkg;

  // Pool geometry
  localparam int MAX_ENTRIES = 65536;
  localparam int IDX_W       = 16;
  localparam int CNT_W       = 17;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  // Request codes
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_DOUBLE    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_CHUNK = 2'd0;
  localparam logic [1:0] CFG_GROW_CHUNK  = 2'd1;
  localparam logic [1:0] CFG_FAST_LIMIT  = 2'd2;

  // Configuration reset values
  localparam logic [CNT_W-1:0] START_CHUNK_RST = CNT_W'(4048);
  localparam logic [CNT_W-1:0] GROW_CHUNK_RST  = CNT_W'(1024);
  localparam logic [CNT_W-1:0] FAST_LIMIT_RST  = CNT_W'(40000);

  // Outcome of a capacity growth attempt
  typedef struct packed {
    logic [CNT_W-1:0] grown;
    logic             grew;
    logic             over_limit;
  } gifl_grow_t;

endpackage
`default_nettype wire

### rtl/gifl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module gifl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/gifl_grow.sv
// Capacity growth: chunk selection, saturation at the pool limit, fast-buffer check.
`default_nettype none
module gifl_grow
  import gifl_pkg::*;
(
  input  wire logic [CNT_W-1:0] pool,
  input  wire logic [CNT_W-1:0] start_chunk,
  input  wire logic [CNT_W-1:0] grow_chunk,
  input  wire logic [CNT_W-1:0] fast_limit,
  output gifl_grow_t            grow
);

  logic [CNT_W-1:0] chunk_raw;
  logic [CNT_W-1:0] chunk;
  logic [CNT_W-1:0] headroom;

  // Pick the chunk; treat a zero chunk as one entry
  always_comb begin
    chunk_raw = (pool == '0) ? start_chunk : grow_chunk;
    chunk     = (chunk_raw == '0) ? CNT_W'(1) : chunk_raw;
    headroom  = MAX_CNT - pool;
  end

  // Saturate at the pool limit
  always_comb begin
    if (pool >= MAX_CNT) begin
      grow.grown = MAX_CNT;
    end else if (chunk >= headroom) begin
      grow.grown = MAX_CNT;
    end else begin
      grow.grown = pool + chunk;
    end
    grow.grew       = grow.grown > pool;
    grow.over_limit = grow.grown > fast_limit;
  end

endmodule
`default_nettype wire

### rtl/growable_index_free_list_unit.sv
// Each request is read in the accept cycle (payload and memory reads), modified and
// written back in the execute cycle, and its result registered at the end of that cycle.
// A new request is taken only while idle; busy holds requests off during the execute cycle.
// Reset: synchronous; clears counters, sets fast_ok and configuration defaults.
// Free-stack and in-use memories are not cleared; entries are read only after written.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module growable_index_free_list_unit
  import gifl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Request channel
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_action,
  input  wire logic [IDX_W-1:0] in_index,
  // Result channel
  output logic                  out_valid,
  output logic [IDX_W-1:0]      out_granted,
  output logic [1:0]            out_status,
  output logic [CNT_W-1:0]      out_capacity,
  output logic                  out_grew,
  output logic                  out_fast_ok,
  // Configuration port
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic             state_r, state_nxt;
  logic [1:0]       act_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] top_r, top_nxt;
  logic [CNT_W-1:0] wm_r, wm_nxt;
  logic [CNT_W-1:0] pool_r, pool_nxt;
  logic             fast_r, fast_nxt;
  logic [CNT_W-1:0] start_chunk_r, grow_chunk_r, fast_limit_r;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_granted_r, out_granted_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [CNT_W-1:0] out_capacity_r;
  logic             out_grew_r, out_grew_nxt;
  logic             out_fast_ok_r;

  logic             accept;
  logic             exec;

  // Memory ports
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic             iu_we;
  logic [IDX_W-1:0] iu_waddr;
  logic             iu_wdata;
  logic [0:0]       iu_rdata;

  gifl_grow_t       grow;
  logic             room;

  assign accept = start && (state_r == S_IDLE);
  assign exec   = (state_r == S_EXEC);
  assign busy   = exec;

  // Read the stack top and the in-use mark as the transaction is taken
  assign stk_raddr = top_r[IDX_W-1:0] - IDX_W'(1);

  gifl_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  gifl_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_inuse_ram (
    .clk   (clk),
    .we    (iu_we),
    .waddr (iu_waddr),
    .wdata (iu_wdata),
    .re    (accept),
    .raddr (in_index),
    .rdata (iu_rdata)
  );

  gifl_grow u_grow (
    .pool        (pool_r),
    .start_chunk (start_chunk_r),
    .grow_chunk  (grow_chunk_r),
    .fast_limit  (fast_limit_r),
    .grow        (grow)
  );

  // Modify and write back in the execute cycle
  always_comb begin
    state_nxt       = accept ? S_EXEC : S_IDLE;
    top_nxt         = top_r;
    wm_nxt          = wm_r;
    pool_nxt        = pool_r;
    fast_nxt        = fast_r;
    out_granted_nxt = '0;
    out_status_nxt  = ST_OK;
    out_grew_nxt    = 1'b0;
    stk_we          = 1'b0;
    stk_waddr       = top_r[IDX_W-1:0];
    stk_wdata       = idx_r;
    iu_we           = 1'b0;
    iu_waddr        = idx_r;
    iu_wdata        = 1'b0;
    room            = wm_r < pool_r;
    if (exec) begin
      case (act_r)
        ACT_ALLOC: begin
          if (top_r != '0) begin
            // Pop the most recently freed index
            top_nxt         = top_r - CNT_W'(1);
            out_granted_nxt = stk_rdata;
            iu_we           = 1'b1;
            iu_waddr        = stk_rdata;
            iu_wdata        = 1'b1;
          end else begin
            // Grow when the watermark has reached capacity
            if (!room && grow.grew) begin
              pool_nxt     = grow.grown;
              out_grew_nxt = 1'b1;
              if (grow.over_limit) begin
                fast_nxt = 1'b0;
              end
              room = wm_r < grow.grown;
            end
            if (room && (wm_r < MAX_CNT)) begin
              out_granted_nxt = wm_r[IDX_W-1:0];
              iu_we           = 1'b1;
              iu_waddr        = wm_r[IDX_W-1:0];
              iu_wdata        = 1'b1;
              wm_nxt          = wm_r + CNT_W'(1);
            end else begin
              out_status_nxt = ST_EXHAUSTED;
            end
          end
        end
        ACT_FREE: begin
          if ({1'b0, idx_r} >= pool_r) begin
            out_status_nxt = ST_RANGE;
          end else if (({1'b0, idx_r} >= wm_r) || !iu_rdata[0]) begin
            out_status_nxt = ST_DOUBLE;
          end else begin
            // Clear the mark and push the index
            iu_we = 1'b1;
            if (top_r < MAX_CNT) begin
              stk_we  = 1'b1;
              top_nxt = top_r + CNT_W'(1);
            end
          end
        end
        ACT_CLEAR: begin
          top_nxt  = '0;
          wm_nxt   = '0;
          pool_nxt = '0;
          fast_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state and pool counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      wm_r        <= '0;
      pool_r      <= '0;
      fast_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      wm_r        <= wm_nxt;
      pool_r      <= pool_nxt;
      fast_r      <= fast_nxt;
      out_valid_r <= exec;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_chunk_r <= START_CHUNK_RST;
      grow_chunk_r  <= GROW_CHUNK_RST;
      fast_limit_r  <= FAST_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_CHUNK: start_chunk_r <= cfg_wdata;
        CFG_GROW_CHUNK:  grow_chunk_r  <= cfg_wdata;
        CFG_FAST_LIMIT:  fast_limit_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Hold the request payload; register the result
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      idx_r <= in_index;
    end
    if (exec) begin
      out_granted_r  <= out_granted_nxt;
      out_status_r   <= out_status_nxt;
      out_capacity_r <= pool_nxt;
      out_grew_r     <= out_grew_nxt;
      out_fast_ok_r  <= fast_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_granted  = out_granted_r;
  assign out_status   = out_status_r;
  assign out_capacity = out_capacity_r;
  assign out_grew     = out_grew_r;
  assign out_fast_ok  = out_fast_ok_r;

endmodule
`default_nettype wire

### sim/tb_growable_index_free_list_unit.sv
// Self-checking testbench for the growable index free list against a pool model.
`timescale 1ns / 100ps
module tb_growable_index_free_list_unit
  import gifl_pkg::*;
();

  localparam int          CYCLE_LIMIT      = 1000000;
  localparam int          SETTLE_CYCLES    = 4;
  localparam int          RANDOM_PER_PHASE = 290;
  localparam int          FILL_ALLOCS      = 24;
  localparam int unsigned REG_MASK         = 32'h1FFFF;
  // Spare codes the block must ignore
  localparam logic [1:0]  ACT_NOP          = 2'd3;
  localparam logic [1:0]  CFG_SPARE        = 2'd3;

  typedef struct {
    logic [1:0]       action;
    logic [IDX_W-1:0] index;
  } pool_request_t;

  typedef struct {
    logic [IDX_W-1:0] granted;
    logic [1:0]       status;
    logic [CNT_W-1:0] capacity;
    logic             grew;
    logic             fast_ok;
  } pool_outcome_t;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             start        = 1'b0;
  logic             busy;
  logic [1:0]       in_action    = ACT_ALLOC;
  logic [IDX_W-1:0] in_index     = '0;
  logic             out_valid;
  logic [IDX_W-1:0] out_granted;
  logic [1:0]       out_status;
  logic [CNT_W-1:0] out_capacity;
  logic             out_grew;
  logic             out_fast_ok;
  logic             cfg_we       = 1'b0;
  logic [1:0]       cfg_index    = CFG_START_CHUNK;
  logic [CNT_W-1:0] cfg_wdata    = '0;

  // Pool model state
  logic [IDX_W-1:0] m_stack [MAX_ENTRIES];
  bit               m_used  [MAX_ENTRIES];
  int unsigned      m_top    = 0;
  int unsigned      m_mark   = 0;
  int unsigned      m_size   = 0;
  bit               m_fast   = 1'b1;
  int unsigned      m_start  = 4048;
  int unsigned      m_grow   = 1024;
  int unsigned      m_limit  = 40000;

  pool_request_t    requests_pending[$];
  pool_outcome_t    outcomes_due[$];
  logic [IDX_W-1:0] granted_ids[$];

  int gap_max        = 0;
  int gap_left       = 0;
  int cycle_count    = 0;
  int mismatch_count = 0;
  int n_accepted     = 0;
  int n_results      = 0;
  int n_growths      = 0;
  int n_reused       = 0;
  int n_settings     = 0;
  int status_seen [4];

  growable_index_free_list_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_index     (in_index),
    .out_valid    (out_valid),
    .out_granted  (out_granted),
    .out_status   (out_status),
    .out_capacity (out_capacity),
    .out_grew     (out_grew),
    .out_fast_ok  (out_fast_ok),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Advance the pool model by one request and queue the outcome it must produce
  function automatic void apply_pool_request(logic [1:0] act, logic [IDX_W-1:0] idx);
    pool_outcome_t    res;
    int unsigned      chunk;
    int unsigned      grown;
    bit               room;
    logic [IDX_W-1:0] id;
    res = '{granted: '0, status: ST_OK, capacity: '0, grew: 1'b0, fast_ok: 1'b0};
    case (act)
      ACT_ALLOC: begin
        if (m_top > 0) begin
          m_top--;
          id = m_stack[m_top];
          m_used[id] = 1'b1;
          res.granted = id;
          granted_ids.insert(granted_ids.size(), id);
          n_reused++;
        end else begin
          room = m_mark < m_size;
          if (!room) begin
            chunk = (m_size == 0) ? m_start : m_grow;
            if (chunk == 0) chunk = 1;
            if (m_size >= MAX_ENTRIES || chunk >= MAX_ENTRIES - m_size) grown = MAX_ENTRIES;
            else grown = m_size + chunk;
            if (grown > m_size) begin
              m_size = grown;
              res.grew = 1'b1;
              if (m_size > m_limit) m_fast = 1'b0;
              room = m_mark < m_size;
            end
          end
          if (room && m_mark < MAX_ENTRIES) begin
            m_used[m_mark] = 1'b1;
            res.granted = m_mark[IDX_W-1:0];
            granted_ids.insert(granted_ids.size(), m_mark[IDX_W-1:0]);
            m_mark++;
          end else begin
            res.status = ST_EXHAUSTED;
          end
        end
      end
      ACT_FREE: begin
        if (idx >= m_size) begin
          res.status = ST_RANGE;
        end else if (idx >= m_mark || !m_used[idx]) begin
          res.status = ST_DOUBLE;
        end else begin
          m_used[idx] = 1'b0;
          if (m_top < MAX_ENTRIES) begin
            m_stack[m_top] = idx;
            m_top++;
          end
        end
      end
      ACT_CLEAR: begin
        m_top  = 0;
        m_mark = 0;
        m_size = 0;
        m_fast = 1'b1;
        granted_ids.delete();
      end
      default: ;
    endcase
    res.capacity = m_size[CNT_W-1:0];
    res.fast_ok  = m_fast;
    outcomes_due.insert(outcomes_due.size(), res);
  endfunction

  // Driver: hold a request until taken, then idle for the drawn gap
  always @(posedge clk) begin
    pool_request_t req;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        apply_pool_request(in_action, in_index);
        n_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (requests_pending.size() != 0) begin
          req = requests_pending.pop_front();
          start     <= 1'b1;
          in_action <= req.action;
          in_index  <= req.index;
          gap_left  <= $urandom_range(0, gap_max);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result strobe with the oldest outcome due
  always @(posedge clk) begin
    pool_outcome_t exp_res;
    if (rst_n && out_valid) begin
      n_results++;
      status_seen[out_status]++;
      if (out_grew === 1'b1) n_growths++;
      if (outcomes_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result granted=%0d status=%0d capacity=%0d",
                   out_granted, out_status, out_capacity);
      end else begin
        exp_res = outcomes_due.pop_front();
        if (out_granted !== exp_res.granted || out_status !== exp_res.status ||
            out_capacity !== exp_res.capacity || out_grew !== exp_res.grew ||
            out_fast_ok !== exp_res.fast_ok) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: result %0d: expected granted=%0d status=%0d cap=%0d grew=%0d fast=%0d",
                     n_results, exp_res.granted, exp_res.status, exp_res.capacity,
                     exp_res.grew, exp_res.fast_ok);
            $display("       got granted=%0d status=%0d cap=%0d grew=%0d fast=%0d",
                     out_granted, out_status, out_capacity, out_grew, out_fast_ok);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d outcomes still due", cycle_count,
               outcomes_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Keep a short backlog in front of the driver
  task automatic queue_request(logic [1:0] act, logic [IDX_W-1:0] idx);
    pool_request_t req;
    while (requests_pending.size() >= 4) @(negedge clk);
    req.action = act;
    req.index  = idx;
    requests_pending.insert(requests_pending.size(), req);
  endtask

  // Wait until every transaction has drained and the block has settled
  task automatic wait_idle();
    while (requests_pending.size() != 0 || start || outcomes_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all registers, plus the spare index which must be ignored
  task automatic set_config(int unsigned s_chunk, int unsigned g_chunk, int unsigned limit);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_CHUNK;
    cfg_wdata <= s_chunk[CNT_W-1:0];
    m_start = s_chunk & REG_MASK;
    @(posedge clk);
    cfg_index <= CFG_GROW_CHUNK;
    cfg_wdata <= g_chunk[CNT_W-1:0];
    m_grow = g_chunk & REG_MASK;
    @(posedge clk);
    cfg_index <= CFG_FAST_LIMIT;
    cfg_wdata <= limit[CNT_W-1:0];
    m_limit = limit & REG_MASK;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= CNT_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_settings++;
  endtask

  // Mostly live alloc/free traffic, with stale frees, wild frees, clears and no-ops mixed in
  task automatic run_random_phase(int unsigned s_chunk, int unsigned g_chunk,
                                  int unsigned limit, int gmax);
    int               roll;
    int               pick;
    logic [1:0]       act;
    logic [IDX_W-1:0] idx;
    wait_idle();
    set_config(s_chunk, g_chunk, limit);
    gap_max = gmax;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      roll = $urandom_range(0, 99);
      idx  = IDX_W'($urandom);
      act  = ACT_ALLOC;
      if (roll >= 45 && roll < 80) begin
        act = ACT_FREE;
        if (granted_ids.size() != 0) begin
          pick = $urandom_range(0, granted_ids.size() - 1);
          idx  = granted_ids[pick];
          granted_ids.delete(pick);
        end
      end else if (roll >= 80 && roll < 90) begin
        act = ACT_FREE;
        idx = IDX_W'($urandom_range(0, m_size + 1));
      end else if (roll >= 90 && roll < 95) begin
        act = ACT_FREE;
      end else if (roll >= 95 && roll < 97) begin
        act = ACT_CLEAR;
      end else if (roll >= 97) begin
        act = ACT_NOP;
      end
      queue_request(act, idx);
    end
  endtask

  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset defaults, empty pool, range and double-free cases
    gap_max = 3;
    queue_request(ACT_FREE, 16'd0);
    queue_request(ACT_NOP, 16'hFFFF);
    queue_request(ACT_ALLOC, 16'd0);
    queue_request(ACT_ALLOC, 16'd0);
    queue_request(ACT_ALLOC, 16'd0);
    queue_request(ACT_FREE, 16'd1);
    queue_request(ACT_FREE, 16'd1);
    queue_request(ACT_ALLOC, 16'd0);
    queue_request(ACT_FREE, 16'd100);
    queue_request(ACT_FREE, 16'd4047);
    queue_request(ACT_FREE, 16'd4048);
    queue_request(ACT_FREE, 16'hFFFF);
    queue_request(ACT_CLEAR, 16'd0);
    queue_request(ACT_ALLOC, 16'd0);

    // Directed: zero chunks grow by one, zero limit drops the fast flag
    wait_idle();
    set_config(0, 0, 0);
    queue_request(ACT_ALLOC, 16'd0);
    queue_request(ACT_ALLOC, 16'd0);
    queue_request(ACT_FREE, 16'd0);
    queue_request(ACT_ALLOC, 16'd0);
    queue_request(ACT_CLEAR, 16'd0);

    // Grow the pool to its limit in one step, then allocate and free near the top
    wait_idle();
    set_config(65536, 1, 65536);
    gap_max = 0;
    for (int n = 0; n < FILL_ALLOCS; n++) queue_request(ACT_ALLOC, 16'd0);
    queue_request(ACT_FREE, 16'hFFFF);
    queue_request(ACT_FREE, 16'd0);
    queue_request(ACT_ALLOC, 16'd0);
    queue_request(ACT_ALLOC, 16'd0);
    queue_request(ACT_ALLOC, 16'd0);
    queue_request(ACT_FREE, 16'hFFFF);
    queue_request(ACT_CLEAR, 16'd0);

    // Random traffic across several register settings and idle patterns
    run_random_phase(1, 1, 3, 12);
    run_random_phase(16, 8, 40, 0);
    run_random_phase(4, 65536, 100, 5);
    run_random_phase(0, 7, 12, 12);
    run_random_phase(4048, 1024, 40000, 2);
    run_random_phase(65535, 2, 65535, 8);

    wait_idle();
    $display("Checked %0d requests (%0d results) over %0d register settings, %0d pool growths",
             n_accepted, n_results, n_settings, n_growths);
    $display("Status ok/exhausted/range/double: %0d/%0d/%0d/%0d, %0d reuses from free stack",
             status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_RANGE],
             status_seen[ST_DOUBLE], n_reused);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/gifl_pkg.sv
rtl/gifl_ram.sv
rtl/gifl_grow.sv
rtl/growable_index_free_list_unit.sv
sim/tb_growable_index_free_list_unit.sv
